[design/bpvc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpvc_pkg
// Shared types and constants for the button / pot volume controller.
// ----------------------------------------------------------------------------
package bpvc_pkg;

    // input item kinds
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_START  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HP_OFS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VOL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEB      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPK_SEL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HP_SEL   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_SEL = 3'd7;
    localparam int CFG_DATA_W = 10;

    // reset values and fixed codes
    localparam logic [9:0] DEB_RESET    = 10'd200;
    localparam logic [9:0] REP_RESET    = 10'd1000;
    localparam logic [4:0] VOL_MAX      = 5'd31;
    localparam logic [7:0] CTRL_PWR_OFF = 8'h02;
    localparam logic [7:0] CTRL_PWR_ON  = 8'h03;

    // default depth of the job queue between front and back
    localparam int JOB_DEPTH = 2;

    // button handler phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DEB_UP,
        PH_REP_UP,
        PH_DEB_DN,
        PH_REP_DN
    } t_phase;

    // configuration registers
    typedef struct packed {
        logic       mode;
        logic [4:0] hp_atten;
        logic [4:0] init_volume;
        logic [9:0] deb_ticks;
        logic [9:0] rep_ticks;
        logic [7:0] spk_sel;
        logic [7:0] hp_sel;
        logic [7:0] ctrl_sel;
    } t_cfg;

    // one job: the write bytes caused by one input item
    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][7:0] bytes;
    } t_job;

endpackage

[design/bpvc_job_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpvc_job_fifo
// Short register queue carrying jobs from the front to the back.
// ----------------------------------------------------------------------------
module bpvc_job_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // a job is never offered to a full queue unless one leaves in the same cycle
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("job queue overflow");

endmodule

[design/bpvc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpvc_front
// Takes input items, runs the button handler and volume state, and builds
// the job of write bytes for each item.
// ----------------------------------------------------------------------------
module bpvc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [1:0]      i_func,
    input  logic            i_up_held,
    input  logic            i_down_held,
    input  logic [9:0]      i_adc_sample,
    input  bpvc_pkg::t_cfg  i_cfg,
    output logic            o_push,
    output bpvc_pkg::t_job  o_job
);
    bpvc_pkg::t_phase r_phase, n_phase;
    logic [4:0] r_volume, n_volume;
    logic       r_power, n_power;
    logic [9:0] r_count, n_count;
    logic       r_pend_up, n_pend_up;
    logic       r_pend_dn, n_pend_dn;
    logic       r_prev_up, n_prev_up;
    logic       r_prev_dn, n_prev_dn;

    logic       up_busy;
    logic       dn_busy;
    logic       held;
    logic       step_up;
    logic       is_deb;
    logic [9:0] limit;
    logic [9:0] cnt_inc;
    logic       do_step;
    logic       do_emit;
    logic       do_prefix;
    logic [4:0] pot_vol;
    logic [4:0] hp_vol;
    logic [2:0] k;

    assign pot_vol = i_adc_sample[9:5];
    assign up_busy = (r_phase == bpvc_pkg::PH_DEB_UP) || (r_phase == bpvc_pkg::PH_REP_UP);
    assign dn_busy = (r_phase == bpvc_pkg::PH_DEB_DN) || (r_phase == bpvc_pkg::PH_REP_DN);
    assign step_up = up_busy;
    assign is_deb  = (r_phase == bpvc_pkg::PH_DEB_UP) || (r_phase == bpvc_pkg::PH_DEB_DN);
    assign held    = up_busy ? i_up_held : i_down_held;
    assign limit   = is_deb ? i_cfg.deb_ticks : i_cfg.rep_ticks;
    assign cnt_inc = r_count + 10'd1;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= bpvc_pkg::PH_IDLE;
            r_volume  <= '0;
            r_power   <= 1'b0;
            r_count   <= '0;
            r_pend_up <= 1'b0;
            r_pend_dn <= 1'b0;
            r_prev_up <= 1'b0;
            r_prev_dn <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_volume  <= n_volume;
            r_power   <= n_power;
            r_count   <= n_count;
            r_pend_up <= n_pend_up;
            r_pend_dn <= n_pend_dn;
            r_prev_up <= n_prev_up;
            r_prev_dn <= n_prev_dn;
        end
    end

    // item handling: next state and job bytes
    always_comb begin
        n_phase   = r_phase;
        n_volume  = r_volume;
        n_power   = r_power;
        n_count   = r_count;
        n_pend_up = r_pend_up;
        n_pend_dn = r_pend_dn;
        n_prev_up = r_prev_up;
        n_prev_dn = r_prev_dn;
        do_step   = 1'b0;
        do_emit   = 1'b0;
        do_prefix = 1'b0;
        hp_vol    = '0;
        k         = '0;
        o_job     = '0;

        if (i_accept) begin
            case (i_func)
                bpvc_pkg::FUNC_TICK: begin
                    if (i_cfg.mode) begin
                        n_phase   = bpvc_pkg::PH_IDLE;
                        n_count   = '0;
                        n_pend_up = 1'b0;
                        n_pend_dn = 1'b0;
                    end else begin
                        if (i_up_held && !r_prev_up && !up_busy) begin
                            n_pend_up = 1'b1;
                        end
                        if (i_down_held && !r_prev_dn && !dn_busy) begin
                            n_pend_dn = 1'b1;
                        end
                        case (r_phase)
                            bpvc_pkg::PH_DEB_UP, bpvc_pkg::PH_REP_UP,
                            bpvc_pkg::PH_DEB_DN, bpvc_pkg::PH_REP_DN: begin
                                if (!held) begin
                                    n_phase = bpvc_pkg::PH_IDLE;
                                    n_count = '0;
                                end else if (cnt_inc >= limit) begin
                                    do_step = 1'b1;
                                    n_count = '0;
                                    if (is_deb) begin
                                        n_phase = step_up ? bpvc_pkg::PH_REP_UP
                                                          : bpvc_pkg::PH_REP_DN;
                                    end
                                end else begin
                                    n_count = cnt_inc;
                                end
                            end
                            default: begin
                                n_phase = bpvc_pkg::PH_IDLE;
                                n_count = '0;
                                if (n_pend_up) begin
                                    n_pend_up = 1'b0;
                                    n_phase   = bpvc_pkg::PH_DEB_UP;
                                end else if (n_pend_dn) begin
                                    n_pend_dn = 1'b0;
                                    n_phase   = bpvc_pkg::PH_DEB_DN;
                                end
                            end
                        endcase
                    end
                    n_prev_up = i_up_held;
                    n_prev_dn = i_down_held;
                end
                bpvc_pkg::FUNC_SAMPLE: begin
                    if (i_cfg.mode && (pot_vol != r_volume)) begin
                        n_volume = pot_vol;
                        do_emit  = 1'b1;
                    end
                end
                bpvc_pkg::FUNC_START: begin
                    do_prefix = 1'b1;
                    do_emit   = 1'b1;
                    n_power   = 1'b1;
                    n_volume  = i_cfg.mode ? pot_vol : i_cfg.init_volume;
                end
                default: begin
                end
            endcase
        end

        // saturating step
        if (do_step) begin
            do_emit = 1'b1;
            if (step_up) begin
                if (r_volume != bpvc_pkg::VOL_MAX) n_volume = r_volume + 5'd1;
            end else begin
                if (r_volume != '0) n_volume = r_volume - 5'd1;
            end
        end

        // power-on prefix of the start item
        if (do_prefix) begin
            o_job.bytes[0] = i_cfg.ctrl_sel | bpvc_pkg::CTRL_PWR_ON;
            k = 3'd1;
        end

        // speaker, headphone and power control bytes
        if (do_emit) begin
            hp_vol = (n_volume > i_cfg.hp_atten) ? n_volume - i_cfg.hp_atten : 5'd0;
            o_job.bytes[k[1:0]] = i_cfg.spk_sel | {3'b000, n_volume};
            k = k + 3'd1;
            o_job.bytes[k[1:0]] = i_cfg.hp_sel | {3'b000, hp_vol};
            k = k + 3'd1;
            if (n_power && (n_volume == '0)) begin
                o_job.bytes[k[1:0]] = i_cfg.ctrl_sel | bpvc_pkg::CTRL_PWR_OFF;
                n_power = 1'b0;
                k = k + 3'd1;
            end else if (!n_power && (n_volume != '0)) begin
                o_job.bytes[k[1:0]] = i_cfg.ctrl_sel | bpvc_pkg::CTRL_PWR_ON;
                n_power = 1'b1;
                k = k + 3'd1;
            end
        end

        o_job.count = k;
    end

    assign o_push = (k != '0);

endmodule

[design/bpvc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpvc_back
// Walks head job bytes into the output register one per cycle unless stalled.
// ----------------------------------------------------------------------------
module bpvc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bpvc_pkg::t_job i_job,
    input  logic           i_job_empty,
    output logic           o_job_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_write_byte,
    output logic           o_is_last
);
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       advance;
    logic       send;
    logic       last_beat;

    assign advance   = !r_out_valid || i_pop;
    assign send      = advance && !i_job_empty;
    assign last_beat = ({1'b0, r_idx} + 3'd1 == i_job.count);
    assign o_job_pop = send && last_beat;

    // beat index within the head job and output valid
    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = send;
        end
        if (send) begin
            n_idx = last_beat ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (send) begin
            r_byte <= i_job.bytes[r_idx];
            r_last <= last_beat;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_write_byte = r_byte;
    assign o_is_last    = r_last;

    // a queued job always carries one to four bytes
    a_job_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_job_empty |-> (i_job.count != 3'd0) && (i_job.count <= 3'd4))
        else $error("job with bad byte count");

    // beat index stays inside the head job
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_job_empty |-> ({1'b0, r_idx} < i_job.count))
        else $error("beat index past job end");

endmodule

[design/button_pot_volume_controller_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_pot_volume_controller_core
// Amplifier volume control from debounced buttons with auto-repeat or from
// potentiometer samples, producing amplifier register write bytes.
// ----------------------------------------------------------------------------
// Usage:
//   input channel : i_push / o_full, one item (tick, pot sample or start) per
//                   beat; an item is taken whenever the job queue has room.
//   result channel: o_empty / i_pop, one write byte per beat, o_is_last set on
//                   the final byte caused by an item; items causing no write
//                   give no beat.
//   config channel: i_cfg_valid / o_cfg_ready, always ready; write only while
//                   the block is idle.
//   path          : an item's job is written into the job queue and its first
//                   byte then moves into the output beat register; earlier
//                   jobs or a stalled output can hold it back.
//   throughput    : the front takes one item per cycle while the queue has
//                   room; the back drives one byte per cycle unless stalled, so
//                   an item with k writes (up to four) holds the back for k bytes;
//                   the job queue (JOB_DEPTH entries) absorbs bursts.
//   stall         : while i_pop is low the output beat holds, the queue fills
//                   and o_full rises; nothing is dropped.
//   reset         : synchronous, active low; registers return to their reset
//                   values, volume 0, power off, queue and output empty.
// ----------------------------------------------------------------------------
module button_pot_volume_controller_core #(
    parameter int JOB_DEPTH = bpvc_pkg::JOB_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [1:0]                        i_func,
    input  logic                              i_up_held,
    input  logic                              i_down_held,
    input  logic [9:0]                        i_adc_sample,
    // results
    output logic                              o_empty,
    input  logic                              i_pop,
    output logic [7:0]                        o_write_byte,
    output logic                              o_is_last,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bpvc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bpvc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    bpvc_pkg::t_cfg r_cfg;
    bpvc_pkg::t_job front_job;
    bpvc_pkg::t_job head_job;
    logic           accept;
    logic           job_push;
    logic           job_pop;
    logic           job_empty;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && !o_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= 1'b0;
            r_cfg.hp_atten    <= '0;
            r_cfg.init_volume <= '0;
            r_cfg.deb_ticks   <= bpvc_pkg::DEB_RESET;
            r_cfg.rep_ticks   <= bpvc_pkg::REP_RESET;
            r_cfg.spk_sel     <= '0;
            r_cfg.hp_sel      <= '0;
            r_cfg.ctrl_sel    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bpvc_pkg::CFG_MODE:     r_cfg.mode        <= i_cfg_data[0];
                bpvc_pkg::CFG_HP_OFS:   r_cfg.hp_atten    <= i_cfg_data[4:0];
                bpvc_pkg::CFG_INIT_VOL: r_cfg.init_volume <= i_cfg_data[4:0];
                bpvc_pkg::CFG_DEB:      r_cfg.deb_ticks   <= i_cfg_data[9:0];
                bpvc_pkg::CFG_REP:      r_cfg.rep_ticks   <= i_cfg_data[9:0];
                bpvc_pkg::CFG_SPK_SEL:  r_cfg.spk_sel     <= i_cfg_data[7:0];
                bpvc_pkg::CFG_HP_SEL:   r_cfg.hp_sel      <= i_cfg_data[7:0];
                bpvc_pkg::CFG_CTRL_SEL: r_cfg.ctrl_sel    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // front: item handling and job build
    bpvc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_func       (i_func),
        .i_up_held    (i_up_held),
        .i_down_held  (i_down_held),
        .i_adc_sample (i_adc_sample),
        .i_cfg        (r_cfg),
        .o_push       (job_push),
        .o_job        (front_job)
    );

    // job queue
    bpvc_job_fifo #(
        .WIDTH ($bits(bpvc_pkg::t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (front_job),
        .i_pop   (job_pop),
        .o_data  (head_job),
        .o_full  (o_full),
        .o_empty (job_empty)
    );

    // back: byte serializer
    bpvc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (head_job),
        .i_job_empty  (job_empty),
        .o_job_pop    (job_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_write_byte (o_write_byte),
        .o_is_last    (o_is_last)
    );

endmodule
